[rtl/rtdc_pkg.sv]
// Shared types and constants of the race time display controller.
package rtdc_pkg;

	// Action codes of an input beat
	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_RESULT  = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// Source codes of a result beat
	localparam logic [1:0] SRC_RUNNING = 2'd0;
	localparam logic [1:0] SRC_RESULT  = 2'd1;
	localparam logic [1:0] SRC_STARTUP = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_STARTUP_WORD = 2'd0;
	localparam logic [1:0] CFG_RESULT_REFRESH = 2'd1;
	localparam logic [1:0] CFG_RUNNING_REFRESH = 2'd2;

	localparam logic [31:0] STARTUP_WORD_RST = 32'd0;
	localparam logic [15:0] RESULT_REFRESH_RST = 16'd500;
	localparam logic [15:0] RUNNING_REFRESH_RST = 16'd100;

	// Display word blanking for running time
	localparam logic [31:0] RUN_KEEP_MASK = 32'h00FF_FF00;
	localparam logic [31:0] RUN_BLANK = 32'h0000_00CC;

	// Time conversion constants
	localparam logic [15:0] MS_PER_MIN = 16'd60000;
	localparam logic [9:0]  MS_PER_SEC = 10'd1000;
	// floor(2^32 / 60000): minute estimate low by at most one
	localparam logic [16:0] MIN_RECIP = 17'd71582;
	// floor(2^16 / 1000): second estimate low by at most one
	localparam logic [6:0]  SEC_RECIP = 7'd65;
	// (x * 205) >> 11 is exact x / 10 for x below 1029
	localparam logic [7:0]  TEN_RECIP = 8'd205;
	localparam logic [3:0]  TEN = 4'd10;

	// Queue between front and back
	localparam int JOB_DEPTH = 4;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

	// One refresh to be rendered: time in ms (or raw startup word) and its source
	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  src;
	} rtdc_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rtdc_q_stat_t;

endpackage

[rtl/rtdc_front.sv]
// Front part: holds display state, decides refreshes on ticks and issues render jobs.
module rtdc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              accept,
	input  logic [1:0]        action,
	input  logic [31:0]       now_ms,
	input  logic [31:0]       time_value,
	input  logic [31:0]       hold_ms,
	output logic              job_valid,
	output rtdc_pkg::rtdc_job_t job
);
	import rtdc_pkg::*;

	logic [31:0] startup_word_q;
	logic [15:0] result_refresh_q;
	logic [15:0] running_refresh_q;

	logic [31:0] hold_until_q;
	logic        hold_forever_q;
	logic [31:0] shown_result_q;
	logic [31:0] run_start_q;
	logic [31:0] last_refresh_q;
	logic        show_startup_q;

	logic        holding;
	logic [31:0] refresh_limit;
	logic        refresh_due;

	assign cfg_ready = 1'b1;

	assign holding = (now_ms < hold_until_q) || hold_forever_q;
	assign refresh_limit = last_refresh_q +
		{16'd0, (holding ? result_refresh_q : running_refresh_q)};
	assign refresh_due = refresh_limit < now_ms;

	assign job_valid = accept && (action == ACT_TICK) && refresh_due;

	always_comb begin
		if (show_startup_q) begin
			job.value = startup_word_q;
			job.src   = SRC_STARTUP;
		end else if (holding) begin
			job.value = shown_result_q;
			job.src   = SRC_RESULT;
		end else begin
			job.value = now_ms - run_start_q;
			job.src   = SRC_RUNNING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_word_q    <= STARTUP_WORD_RST;
			result_refresh_q  <= RESULT_REFRESH_RST;
			running_refresh_q <= RUNNING_REFRESH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STARTUP_WORD:    startup_word_q    <= cfg_data;
				CFG_RESULT_REFRESH:  result_refresh_q  <= cfg_data[15:0];
				CFG_RUNNING_REFRESH: running_refresh_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_until_q   <= '0;
			hold_forever_q <= 1'b0;
			shown_result_q <= '0;
			run_start_q    <= '0;
			last_refresh_q <= '0;
			show_startup_q <= 1'b1;
		end else if (accept) begin
			case (action)
				ACT_RESULT: begin
					if (shown_result_q != time_value) begin
						if (hold_ms != 32'd0) begin
							hold_until_q   <= now_ms + hold_ms;
							hold_forever_q <= 1'b0;
						end else begin
							hold_forever_q <= 1'b1;
						end
						shown_result_q <= time_value;
						last_refresh_q <= '0;
						show_startup_q <= 1'b0;
					end
				end
				ACT_RESTART: begin
					run_start_q    <= (time_value == 32'd0) ? now_ms : time_value;
					hold_forever_q <= 1'b0;
					show_startup_q <= 1'b0;
				end
				ACT_TICK: begin
					if (refresh_due) begin
						last_refresh_q <= now_ms;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

[rtl/rtdc_fifo.sv]
// Short job queue between the front and back parts.
module rtdc_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  rtdc_pkg::rtdc_job_t    wr_job,
	input  logic                   rd_en,
	output rtdc_pkg::rtdc_job_t    rd_job,
	output rtdc_pkg::rtdc_q_stat_t stat
);
	import rtdc_pkg::*;

	rtdc_job_t              slot_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0]   wr_ptr_q;
	logic [JOB_PTR_W-1:0]   rd_ptr_q;
	logic [JOB_CNT_W-1:0]   count_q;
	logic                   do_wr;
	logic                   do_rd;

	assign stat.full  = (count_q == JOB_CNT_W'(JOB_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr = wr_en && !stat.full;
	assign do_rd = rd_en && !stat.empty;
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/rtdc_back.sv]
// Back part: converts milliseconds to the packed display word and holds the result beat.
module rtdc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rtdc_pkg::rtdc_job_t in_job,
	output logic                in_take,
	output logic                empty,
	input  logic                pop,
	output logic [31:0]         display_word,
	output logic [1:0]          source
);
	import rtdc_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic out_valid_q;

	rtdc_job_t job_s1, job_s2, job_s3, job_s4, job_s5, job_s6, job_s7;

	logic [48:0] min_prod;
	logic [16:0] min_est_s1;
	logic [32:0] min_back;
	logic [16:0] min_s2;
	logic [16:0] rem0_s2;
	logic [11:0] min_s3, min_s4, min_s5, min_s6, min_s7;
	logic [15:0] rem_s3, rem_s4;
	logic [22:0] sec_prod;
	logic [5:0]  sec_est_s4, sec_est_s5;
	logic [15:0] sec_back;
	logic [10:0] msec0_s5;
	logic [5:0]  sec_s6;
	logic [9:0]  msec_s6;
	logic [13:0] sec_t_prod;
	logic [3:0]  sec_t, sec_t_s7;
	logic [7:0]  sec_t_ten;
	logic [3:0]  sec_o_s7;
	logic [17:0] q10_prod;
	logic [6:0]  q10, q10_s7;
	logic [10:0] q10_ten;
	logic [3:0]  ms_o_s7;
	logic [14:0] h_prod;
	logic [3:0]  ms_h;
	logic [7:0]  h_ten;
	logic [3:0]  ms_t;
	logic [31:0] packed_word;
	logic [31:0] final_word;

	assign adv = !out_valid_q || pop;
	assign in_take = adv && in_valid;
	assign empty = !out_valid_q;

	// minute estimate, then remainder, then one correction
	assign min_prod = in_job.value * MIN_RECIP;
	assign min_back = min_est_s1 * MS_PER_MIN;
	assign sec_prod = rem_s3 * SEC_RECIP;
	assign sec_back = sec_est_s4 * MS_PER_SEC;

	// decimal digits of seconds and milliseconds
	assign sec_t_prod = sec_s6 * TEN_RECIP;
	assign sec_t = {1'b0, sec_t_prod[13:11]};
	assign sec_t_ten = sec_t * TEN;
	assign q10_prod = msec_s6 * TEN_RECIP;
	assign q10 = q10_prod[17:11];
	assign q10_ten = q10 * TEN;
	assign h_prod = q10_s7 * TEN_RECIP;
	assign ms_h = h_prod[14:11];
	assign h_ten = ms_h * TEN;
	assign ms_t = q10_s7[3:0] - h_ten[3:0];

	assign packed_word = {min_s7, sec_t_s7, sec_o_s7, ms_h, ms_t, ms_o_s7};

	always_comb begin
		case (job_s7.src)
			SRC_STARTUP: final_word = job_s7.value;
			SRC_RUNNING: final_word = (packed_word & RUN_KEEP_MASK) | RUN_BLANK;
			default:     final_word = packed_word;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			job_s1     <= in_job;
			min_est_s1 <= min_prod[48:32];

			job_s2  <= job_s1;
			min_s2  <= min_est_s1;
			rem0_s2 <= job_s1.value[16:0] - min_back[16:0];

			job_s3 <= job_s2;
			if (rem0_s2 >= {1'b0, MS_PER_MIN}) begin
				min_s3 <= min_s2[11:0] + 12'd1;
				rem_s3 <= 16'(rem0_s2 - {1'b0, MS_PER_MIN});
			end else begin
				min_s3 <= min_s2[11:0];
				rem_s3 <= rem0_s2[15:0];
			end

			job_s4     <= job_s3;
			min_s4     <= min_s3;
			rem_s4     <= rem_s3;
			sec_est_s4 <= sec_prod[21:16];

			job_s5     <= job_s4;
			min_s5     <= min_s4;
			sec_est_s5 <= sec_est_s4;
			msec0_s5   <= rem_s4[10:0] - sec_back[10:0];

			job_s6 <= job_s5;
			min_s6 <= min_s5;
			if (msec0_s5 >= {1'b0, MS_PER_SEC}) begin
				sec_s6  <= sec_est_s5 + 6'd1;
				msec_s6 <= 10'(msec0_s5 - {1'b0, MS_PER_SEC});
			end else begin
				sec_s6  <= sec_est_s5;
				msec_s6 <= msec0_s5[9:0];
			end

			job_s7   <= job_s6;
			min_s7   <= min_s6;
			sec_t_s7 <= sec_t;
			sec_o_s7 <= sec_s6[3:0] - sec_t_ten[3:0];
			q10_s7   <= q10;
			ms_o_s7  <= msec_s6[3:0] - q10_ten[3:0];

			display_word <= final_word;
			source       <= job_s7.src;
		end
	end

endmodule

[rtl/race_time_display_controller_core.sv]
// Top level of the race time display controller: front, job queue and back.
// Path: a refreshing tick is written into the queue, then passes the render pipeline registers to the result ports.
// Throughput: one input beat per cycle while the queue is not full; the queue and the 8-stage
//   render pipeline take one job a cycle while pop keeps up, and the pipeline holds while a result waits.
// Reset: arst_n clears queue, pipeline valids and display state at once; registers
//   return to startup word 0, refresh spacings 500 and 100 ms.
module race_time_display_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input beats
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [31:0] now_ms,
	input  logic [31:0] time_value,
	input  logic [31:0] hold_ms,
	// result beats
	output logic        empty,
	input  logic        pop,
	output logic [31:0] display_word,
	output logic [1:0]  source
);
	import rtdc_pkg::*;

	logic         accept;
	logic         job_valid;
	rtdc_job_t    front_job;
	rtdc_job_t    back_job;
	rtdc_q_stat_t q_stat;
	logic         back_take;

	// Take a beat whenever the queue has room, even a tick that does not refresh
	// and so writes no job into the queue.
	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	// Front: keep hold/run state, classify the beat, emit a render job on refresh.
	rtdc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.action     (action),
		.now_ms     (now_ms),
		.time_value (time_value),
		.hold_ms    (hold_ms),
		.job_valid  (job_valid),
		.job        (front_job)
	);

	// Queue: decouple the decision from the conversion so each side stalls alone.
	rtdc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_valid),
		.wr_job (front_job),
		.rd_en  (back_take),
		.rd_job (back_job),
		.stat   (q_stat)
	);

	// Back: split ms into minutes, seconds and BCD digits, blank running time,
	// and hold the finished beat until popped.
	rtdc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (!q_stat.empty),
		.in_job       (back_job),
		.in_take      (back_take),
		.empty        (empty),
		.pop          (pop),
		.display_word (display_word),
		.source       (source)
	);

endmodule
